>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mts_pkg.sv
// Types and constants shared by the move-to-target stepper modules.
package mts_pkg;

    localparam int COORD_W    = 24;
    localparam int OFF_W      = 25;
    localparam int SPEED_W    = 16;
    localparam int THR_W      = 32;
    localparam int PROD_W     = 50;
    localparam int ROOT_W     = 25;
    localparam int SQREM_W    = 27;
    localparam int QUO_W      = 16;
    localparam int SQRT_ITERS = 25;
    localparam int CNT_W      = 5;

    localparam logic [THR_W-1:0] THR_RESET = 32'd65536;
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_ITERS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

    typedef enum logic [1:0] {
        MODE_PLACE = 2'd0,
        MODE_AIM   = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_OFFSET,
        DP_SQ_X,
        DP_SQ_Y,
        DP_SQ_SUM,
        DP_CMP,
        DP_MOVE,
        DP_STEP_SPECIAL,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_MUL_SPEED,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_END,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis_y;
    } dp_cmd_t;

    typedef struct packed {
        logic near;
        logic ox_zero;
    } dp_sts_t;

endpackage

>>> rtl/mts_datapath.sv
// Datapath: position, goal and step state, shared multiplier, sqrt and divide steps.
module mts_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mts_pkg::dp_cmd_t               cmd,
    output mts_pkg::dp_sts_t               sts,
    input  logic                           cfg_wr_en,
    input  logic [mts_pkg::THR_W-1:0]      cfg_wr_data,
    input  logic [1:0]                     s_mode,
    input  logic signed [mts_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [mts_pkg::COORD_W-1:0] s_coord_y,
    input  logic [mts_pkg::SPEED_W-1:0]    s_speed,
    output logic signed [mts_pkg::COORD_W-1:0] m_pos_x,
    output logic signed [mts_pkg::COORD_W-1:0] m_pos_y,
    output logic signed [mts_pkg::COORD_W-1:0] m_step_x,
    output logic signed [mts_pkg::COORD_W-1:0] m_step_y,
    output logic                           m_arrived
);
    import mts_pkg::*;

    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, goal_x_reg, goal_y_reg;
    logic [COORD_W-1:0] delta_x_reg, delta_y_reg;
    logic [THR_W-1:0]   thr_reg;

    logic [SPEED_W-1:0] speed_reg;
    logic [OFF_W-1:0]   ax_reg, ay_reg;
    logic               sx_reg, sy_reg, ox_zero_reg, oy_zero_reg;
    logic [PROD_W-1:0]  prod_reg, acc_reg, sq_n_reg;
    logic [SQREM_W-1:0] sq_rem_reg;
    logic [ROOT_W-1:0]  root_reg, div_rem_reg;
    logic [QUO_W-1:0]   div_lo_reg, quo_reg;
    logic               arrived_reg;

    logic [COORD_W-1:0] out_pos_x_reg, out_pos_y_reg, out_step_x_reg, out_step_y_reg;
    logic               out_arrived_reg;

    logic [OFF_W-1:0]   ox, oy, ax, ay;
    logic [OFF_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  product;
    logic [SQREM_W+1:0] sq_shift, sq_trial, sq_diff;
    logic               sq_ge;
    logic [ROOT_W:0]    div_t, div_d, div_diff;
    logic               div_ge;
    logic [COORD_W-1:0] step_mag;

    function automatic logic [COORD_W-1:0] apply_sign(input logic neg,
                                                      input logic [COORD_W-1:0] mag);
        apply_sign = neg ? (COORD_W'(0) - mag) : mag;
    endfunction

    assign ox = {goal_x_reg[COORD_W-1], goal_x_reg} - {pos_x_reg[COORD_W-1], pos_x_reg};
    assign oy = {goal_y_reg[COORD_W-1], goal_y_reg} - {pos_y_reg[COORD_W-1], pos_y_reg};
    assign ax = ox[OFF_W-1] ? (OFF_W'(0) - ox) : ox;
    assign ay = oy[OFF_W-1] ? (OFF_W'(0) - oy) : oy;

    always_comb begin
        unique case (cmd.op)
            DP_SQ_Y: begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            DP_MUL_SPEED: begin
                mul_a = cmd.axis_y ? ay_reg : ax_reg;
                mul_b = OFF_W'(speed_reg);
            end
            default: begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign sq_shift = {sq_rem_reg, sq_n_reg[PROD_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_shift >= sq_trial;
    assign sq_diff  = sq_shift - sq_trial;

    assign div_t    = {div_rem_reg, div_lo_reg[QUO_W-1]};
    assign div_d    = {1'b0, root_reg};
    assign div_ge   = div_t >= div_d;
    assign div_diff = div_t - div_d;

    assign step_mag = COORD_W'(quo_reg);

    assign sts.near    = acc_reg <= PROD_W'(thr_reg);
    assign sts.ox_zero = ox_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            delta_x_reg <= '0;
            delta_y_reg <= '0;
            thr_reg     <= THR_RESET;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            unique case (cmd.op)
                DP_LOAD: begin
                    if (s_mode == MODE_PLACE) begin
                        pos_x_reg <= s_coord_x;
                        pos_y_reg <= s_coord_y;
                    end else if (s_mode == MODE_AIM) begin
                        goal_x_reg <= s_coord_x;
                        goal_y_reg <= s_coord_y;
                    end
                end
                DP_MOVE: begin
                    pos_x_reg <= pos_x_reg + delta_x_reg;
                    pos_y_reg <= pos_y_reg + delta_y_reg;
                end
                DP_STEP_SPECIAL: begin
                    delta_x_reg <= '0;
                    delta_y_reg <= oy_zero_reg ? '0
                                               : apply_sign(sy_reg, COORD_W'(speed_reg));
                end
                DP_DIV_END: begin
                    if (cmd.axis_y) begin
                        delta_y_reg <= apply_sign(sy_reg, step_mag);
                    end else begin
                        delta_x_reg <= apply_sign(sx_reg, step_mag);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_LOAD: begin
                if (s_mode == MODE_AIM) begin
                    speed_reg <= s_speed;
                end
            end
            DP_OFFSET: begin
                ax_reg      <= ax;
                ay_reg      <= ay;
                sx_reg      <= ox[OFF_W-1];
                sy_reg      <= oy[OFF_W-1];
                ox_zero_reg <= (ox == '0);
                oy_zero_reg <= (oy == '0);
            end
            DP_SQ_X: begin
                prod_reg <= product;
            end
            DP_SQ_Y: begin
                acc_reg  <= prod_reg;
                prod_reg <= product;
            end
            DP_SQ_SUM: begin
                acc_reg <= acc_reg + prod_reg;
            end
            DP_CMP: begin
                arrived_reg <= sts.near;
            end
            DP_SQRT_INIT: begin
                sq_n_reg   <= acc_reg;
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            DP_SQRT_STEP: begin
                sq_n_reg   <= {sq_n_reg[PROD_W-3:0], 2'b00};
                sq_rem_reg <= sq_ge ? sq_diff[SQREM_W-1:0] : sq_shift[SQREM_W-1:0];
                root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
            end
            DP_MUL_SPEED: begin
                prod_reg <= product;
            end
            DP_DIV_INIT: begin
                div_rem_reg <= prod_reg[QUO_W +: ROOT_W];
                div_lo_reg  <= prod_reg[QUO_W-1:0];
                quo_reg     <= '0;
            end
            DP_DIV_STEP: begin
                div_rem_reg <= div_ge ? div_diff[ROOT_W-1:0] : div_t[ROOT_W-1:0];
                div_lo_reg  <= {div_lo_reg[QUO_W-2:0], 1'b0};
                quo_reg     <= {quo_reg[QUO_W-2:0], div_ge};
            end
            DP_PUBLISH: begin
                out_pos_x_reg   <= pos_x_reg;
                out_pos_y_reg   <= pos_y_reg;
                out_step_x_reg  <= delta_x_reg;
                out_step_y_reg  <= delta_y_reg;
                out_arrived_reg <= arrived_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_pos_x   = out_pos_x_reg;
    assign m_pos_y   = out_pos_y_reg;
    assign m_step_x  = out_step_x_reg;
    assign m_step_y  = out_step_y_reg;
    assign m_arrived = out_arrived_reg;

endmodule

>>> rtl/mts_ctrl.sv
// Controller: sequences place, aim and tick through the datapath and owns the handshakes.
module mts_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    output logic             m_valid,
    input  logic             m_ready,
    output mts_pkg::dp_cmd_t cmd,
    input  mts_pkg::dp_sts_t sts
);
    import mts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CMP,
        S_MOVE,
        S_SPECIAL,
        S_SQRT_INIT,
        S_SQRT,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic             pass2_reg, pass2_next;
    logic             axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             publish;

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign publish    = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pass2_next = pass2_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd.op     = DP_NOP;
        cmd.axis_y = axis_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    mode_next  = s_mode;
                    pass2_next = 1'b0;
                    axis_next  = 1'b0;
                    state_next = S_OFF;
                end
            end
            S_OFF: begin
                cmd.op     = DP_OFFSET;
                state_next = S_SQX;
            end
            S_SQX: begin
                cmd.op     = DP_SQ_X;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.op     = DP_SQ_Y;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.op     = DP_SQ_SUM;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.op = DP_CMP;
                priority if (mode_reg == MODE_TICK && !pass2_reg && !sts.near) begin
                    state_next = S_MOVE;
                end else if (mode_reg == MODE_AIM) begin
                    state_next = sts.ox_zero ? S_SPECIAL : S_SQRT_INIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOVE: begin
                cmd.op     = DP_MOVE;
                pass2_next = 1'b1;
                state_next = S_OFF;
            end
            S_SPECIAL: begin
                cmd.op     = DP_STEP_SPECIAL;
                state_next = S_DONE;
            end
            S_SQRT_INIT: begin
                cmd.op     = DP_SQRT_INIT;
                cnt_next   = SQRT_LAST;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op = DP_SQRT_STEP;
                if (cnt_reg == '0) begin
                    state_next = S_MUL;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_MUL: begin
                cmd.op     = DP_MUL_SPEED;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.op     = DP_DIV_INIT;
                cnt_next   = DIV_LAST;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = DP_DIV_STEP;
                if (cnt_reg == '0) begin
                    state_next = S_DIV_END;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DIV_END: begin
                cmd.op = DP_DIV_END;
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = S_MUL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (publish) begin
                    cmd.op     = DP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= '0;
            pass2_reg   <= 1'b0;
            axis_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            pass2_reg   <= pass2_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/move_to_target_stepper.sv
// Top level of the move-to-target stepper: controller plus datapath.
// Aim time is set by the 25-step square root and two 16-step divides on one unit.
// One item at a time; the input is ready again in the same cycle that its result becomes valid.
// Synchronous active-low reset clears position, goal, step and control; threshold = 65536.
module move_to_target_stepper (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mts_pkg::THR_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_mode,
    input  logic signed [mts_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [mts_pkg::COORD_W-1:0] s_coord_y,
    input  logic [mts_pkg::SPEED_W-1:0]        s_speed,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mts_pkg::COORD_W-1:0] m_pos_x,
    output logic signed [mts_pkg::COORD_W-1:0] m_pos_y,
    output logic signed [mts_pkg::COORD_W-1:0] m_step_x,
    output logic signed [mts_pkg::COORD_W-1:0] m_step_y,
    output logic                               m_arrived
);
    import mts_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    mts_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_mode      (s_mode),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_speed     (s_speed),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_step_x    (m_step_x),
        .m_step_y    (m_step_y),
        .m_arrived   (m_arrived)
    );

endmodule

>>> rtl/mts_checker.sv
// Port-level checker for the move-to-target stepper, bound to the top level.
`include "assert_macros.svh"

module mts_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [mts_pkg::COORD_W-1:0] m_pos_x,
    input logic signed [mts_pkg::COORD_W-1:0] m_pos_y,
    input logic signed [mts_pkg::COORD_W-1:0] m_step_x,
    input logic signed [mts_pkg::COORD_W-1:0] m_step_y,
    input logic                               m_arrived
);

    `ASSERT_CLK(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid,
                "result dropped before transfer")
    `ASSERT_CLK(a_m_payload_hold, aclk, aresetn,
                m_valid && !m_ready |=> $stable({m_pos_x, m_pos_y, m_step_x, m_step_y,
                                                 m_arrived}),
                "result changed while stalled")
    `ASSERT_CLK(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready,
                "second item taken while busy")
    `ASSERT_CLK(a_result_frees_input, aclk, aresetn, $rose(m_valid) |-> s_ready,
                "input not ready after result")
    `ASSERT_CLK_NORST(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind move_to_target_stepper mts_checker u_mts_checker (.*);
